FILE: rtl/hsl2rgb_pkg.sv
// ----------------------------------------------------------------------------
// hsl2rgb_pkg
// Shared types and constants for the HSL to RGB color converter.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package hsl2rgb_pkg;

  localparam int unsigned NUM_STAGES = 5;

  // Color channel math: value scaled by 600000 maps to a byte as v*17/40000.
  // v above CLAMP_LIM would give more than 255.
  localparam logic [19:0] CLAMP_LIM   = 20'd602352;
  // floor(y/625) == (y * RECIP_625) >> RECIP_SHIFT for y < 2^28/169
  localparam logic [18:0] RECIP_625   = 19'd429497;
  localparam int unsigned RECIP_SHIFT = 28;

  typedef struct packed {
    logic [8:0] hue_deg;
    logic [6:0] sat_pct;
    logic [6:0] lum_pct;
    logic [7:0] alpha_in;
  } hsl2rgb_in_t;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [7:0] alpha_out;
  } hsl2rgb_out_t;

  // Hue segment of one channel angle
  typedef enum logic [1:0] {
    SEG_RAMP,
    SEG_HIGH,
    SEG_LOW
  } hsl2rgb_seg_e;

  // Per-stage load strobes for the channel datapath
  typedef struct packed {
    logic ld2;
    logic ld3;
    logic ld4;
    logic ld5;
  } hsl2rgb_ctl_t;

endpackage

FILE: rtl/hsl2rgb_channel.sv
// ----------------------------------------------------------------------------
// hsl2rgb_channel
// One color channel: hue segment decode, piecewise interpolation between
// p and q, clamp and scaling to an 8-bit value. Stages 2 to 5.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module hsl2rgb_channel
  import hsl2rgb_pkg::*;
(
  input  logic               clk_i,
  input  hsl2rgb_ctl_t       ctl_i,
  input  logic [8:0]         angle_i,
  input  logic signed [15:0] p_i,
  input  logic signed [15:0] q_i,
  input  logic signed [15:0] qmp_i,
  output logic [7:0]         byte_o
);

  hsl2rgb_seg_e       seg_d, seg_q;
  logic [6:0]         frac_d, frac_q;
  logic signed [23:0] v_d, v_q;
  logic [17:0]        y_d, y_q;
  logic [7:0]         byte_d, byte_q;

  // stage 2: segment decode
  always_comb begin
    if (angle_i < 9'd60) begin
      seg_d  = SEG_RAMP;
      frac_d = angle_i[6:0];
    end else if (angle_i < 9'd180) begin
      seg_d  = SEG_HIGH;
      frac_d = 7'd0;
    end else if (angle_i < 9'd240) begin
      seg_d  = SEG_RAMP;
      frac_d = 7'(9'd240 - angle_i);
    end else begin
      seg_d  = SEG_LOW;
      frac_d = 7'd0;
    end
  end

  // stage 3: scaled channel value (x600000)
  logic signed [23:0] p60, q60, ramp;
  always_comb begin
    p60  = 24'(p_i) * 24'sd60;
    q60  = 24'(q_i) * 24'sd60;
    ramp = 24'(qmp_i) * $signed(24'(frac_q));
    case (seg_q)
      SEG_RAMP: v_d = p60 + ramp;
      SEG_HIGH: v_d = q60;
      SEG_LOW:  v_d = p60;
      default:  v_d = p60;
    endcase
  end

  // stage 4: clamp, then v*17/64
  logic [19:0] v_clamp;
  logic [23:0] x17;
  always_comb begin
    if (v_q >= $signed({4'b0, CLAMP_LIM})) begin
      v_clamp = CLAMP_LIM;
    end else begin
      v_clamp = v_q[19:0];
    end
    x17 = 24'(v_clamp) * 24'd17;
    if (v_q <= 24'sd0) begin
      y_d = 18'd0;
    end else begin
      y_d = x17[23:6];
    end
  end

  // stage 5: divide by 625 through the reciprocal
  logic [36:0] prod;
  always_comb begin
    prod   = 37'(y_q) * 37'(RECIP_625);
    byte_d = prod[RECIP_SHIFT+7:RECIP_SHIFT];
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.ld2) begin
      seg_q  <= seg_d;
      frac_q <= frac_d;
    end
    if (ctl_i.ld3) begin
      v_q <= v_d;
    end
    if (ctl_i.ld4) begin
      y_q <= y_d;
    end
    if (ctl_i.ld5) begin
      byte_q <= byte_d;
    end
  end

  assign byte_o = byte_q;

endmodule

FILE: rtl/hsl_to_rgb_converter.sv
// ----------------------------------------------------------------------------
// hsl_to_rgb_converter
// Each accepted request moves through stages 1 to 5; the result is presented
// from the stage 5 registers. Throughput: one pixel per cycle unless the
// output stalls; five pipeline stages, each holds one pixel.
// Stages collapse bubbles; in_stall_o rises only when all stages are full
// and the output is stalled. Reset clears all stage valid bits.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module hsl_to_rgb_converter
  import hsl2rgb_pkg::*;
(
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         in_valid_i,
  output logic         in_stall_o,
  input  hsl2rgb_in_t  in_req_i,
  output logic         out_valid_o,
  input  logic         out_stall_i,
  output hsl2rgb_out_t out_req_o
);

  logic [NUM_STAGES-1:0] valid_q;
  logic [NUM_STAGES-1:0] ready;
  logic [NUM_STAGES-1:0] vprev;
  hsl2rgb_ctl_t          ctl;
  logic                  ld1;

  always_comb begin
    ready[NUM_STAGES-1] = !valid_q[NUM_STAGES-1] || !out_stall_i;
    for (int k = NUM_STAGES - 2; k >= 0; k--) begin
      ready[k] = !valid_q[k] || ready[k+1];
    end
    vprev[0] = in_valid_i;
    for (int k = 1; k < NUM_STAGES; k++) begin
      vprev[k] = valid_q[k-1];
    end
  end

  assign ld1      = ready[0] && vprev[0];
  assign ctl.ld2  = ready[1] && vprev[1];
  assign ctl.ld3  = ready[2] && vprev[2];
  assign ctl.ld4  = ready[3] && vprev[3];
  assign ctl.ld5  = ready[4] && vprev[4];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      for (int k = 0; k < NUM_STAGES; k++) begin
        if (ready[k]) begin
          valid_q[k] <= vprev[k];
        end
      end
    end
  end

  // stage 1: channel angles, l*s
  logic [9:0]  hr_sum;
  logic [8:0]  ang_r_d, ang_g_d, ang_b_d;
  logic [8:0]  ang_r_q, ang_g_q, ang_b_q;
  logic [6:0]  sat1_q, lum1_q;
  logic [13:0] ls_d, ls1_q;
  logic [7:0]  alpha_q [NUM_STAGES];

  always_comb begin
    hr_sum = {1'b0, in_req_i.hue_deg} + 10'd120;
    if (hr_sum > 10'd360) begin
      ang_r_d = 9'(hr_sum - 10'd360);
    end else begin
      ang_r_d = hr_sum[8:0];
    end
    if (in_req_i.hue_deg > 9'd360) begin
      ang_g_d = in_req_i.hue_deg - 9'd360;
    end else begin
      ang_g_d = in_req_i.hue_deg;
    end
    // h-120 wraps up by a turn below zero, down by a turn above 360
    if (in_req_i.hue_deg < 9'd120) begin
      ang_b_d = in_req_i.hue_deg + 9'd240;
    end else if (in_req_i.hue_deg > 9'd480) begin
      ang_b_d = in_req_i.hue_deg - 9'd480;
    end else begin
      ang_b_d = in_req_i.hue_deg - 9'd120;
    end
    ls_d = 14'(in_req_i.lum_pct) * 14'(in_req_i.sat_pct);
  end

  // stage 2: p and q, both scaled by 10000
  logic [14:0]        q_lo, q_hi;
  logic signed [15:0] q_d, p_d, qmp_d;
  logic signed [15:0] q2_q, p2_q, qmp2_q;
  logic [6:0]         sat2_q;

  always_comb begin
    q_lo = 15'(lum1_q) * 15'd100 + 15'(ls1_q);
    q_hi = (15'(lum1_q) + 15'(sat1_q)) * 15'd100 - 15'(ls1_q);
    if (lum1_q < 7'd50) begin
      q_d = $signed({1'b0, q_lo});
    end else begin
      q_d = $signed({1'b0, q_hi});
    end
    p_d   = $signed({1'b0, 15'(lum1_q) * 15'd200}) - q_d;
    qmp_d = q_d - p_d;
  end

  always_ff @(posedge clk_i) begin
    if (ld1) begin
      ang_r_q    <= ang_r_d;
      ang_g_q    <= ang_g_d;
      ang_b_q    <= ang_b_d;
      sat1_q     <= in_req_i.sat_pct;
      lum1_q     <= in_req_i.lum_pct;
      ls1_q      <= ls_d;
      alpha_q[0] <= in_req_i.alpha_in;
    end
    if (ctl.ld2) begin
      q2_q       <= q_d;
      p2_q       <= p_d;
      qmp2_q     <= qmp_d;
      sat2_q     <= sat1_q;
      alpha_q[1] <= alpha_q[0];
    end
    if (ctl.ld3) begin
      alpha_q[2] <= alpha_q[1];
    end
    if (ctl.ld4) begin
      alpha_q[3] <= alpha_q[2];
    end
    if (ctl.ld5) begin
      alpha_q[4] <= alpha_q[3];
    end
  end

  logic [7:0] red_b, green_b, blue_b;

  hsl2rgb_channel u_red (
    .clk_i   (clk_i),
    .ctl_i   (ctl),
    .angle_i (ang_r_q),
    .p_i     (p2_q),
    .q_i     (q2_q),
    .qmp_i   (qmp2_q),
    .byte_o  (red_b)
  );

  hsl2rgb_channel u_green (
    .clk_i   (clk_i),
    .ctl_i   (ctl),
    .angle_i (ang_g_q),
    .p_i     (p2_q),
    .q_i     (q2_q),
    .qmp_i   (qmp2_q),
    .byte_o  (green_b)
  );

  hsl2rgb_channel u_blue (
    .clk_i   (clk_i),
    .ctl_i   (ctl),
    .angle_i (ang_b_q),
    .p_i     (p2_q),
    .q_i     (q2_q),
    .qmp_i   (qmp2_q),
    .byte_o  (blue_b)
  );

  assign in_stall_o            = !ready[0];
  assign out_valid_o           = valid_q[NUM_STAGES-1];
  assign out_req_o.red         = red_b;
  assign out_req_o.green       = green_b;
  assign out_req_o.blue        = blue_b;
  assign out_req_o.alpha_out   = alpha_q[NUM_STAGES-1];

  // input is held off only with the whole pipe full
  a_stall_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (&valid_q))
    else $error("input stalled with a free pipeline stage");

  // wrapped angles stay within one turn
  a_angle_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_q[0] |-> (ang_r_q <= 9'd360 && ang_g_q <= 9'd360 && ang_b_q <= 9'd360))
    else $error("channel angle out of range");

  // zero saturation gives p equal to q (gray)
  a_gray: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctl.ld2 |=> (sat2_q != 7'd0 || p2_q == q2_q))
    else $error("p and q differ at zero saturation");

endmodule
